@@ rtl/core/nfcfr_pkg.sv @@
// Package with the types and constants of the NFC controller frame receiver.
package nfcfr_pkg;

    localparam int CMD_W     = 8;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [23:0] START_CODE      = 24'h0000FF;
    localparam logic [7:0]  DIR_BYTE        = 8'hD5;
    localparam logic [7:0]  DCS_SEED        = 8'h2B;
    localparam logic [7:0]  ERR_LEN_BYTE    = 8'h01;
    localparam logic [7:0]  ALL_ONES_BYTE   = 8'hFF;
    localparam logic [7:0]  POSTAMBLE       = 8'h00;
    localparam logic [8:0]  NORMAL_LEN_SUM  = 9'h100;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd264;
    localparam logic [LEN_W-1:0] MIN_RAW_LEN     = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_COMMAND = 1'b0,
        CFG_MAX_PAYLOAD      = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ERRSKIP = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_DIR     = 3'd3,
        PH_CODE    = 3'd4,
        PH_DATA    = 3'd5,
        PH_DCS     = 3'd6,
        PH_POST    = 3'd7
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_START     = 4'd1,
        ST_LEN_CSUM  = 4'd2,
        ST_ERR_FRAME = 4'd3,
        ST_TOO_LONG  = 4'd4,
        ST_DIRECTION = 4'd5,
        ST_RESP_CODE = 4'd6,
        ST_DATA_CSUM = 4'd7,
        ST_POSTAMBLE = 4'd8
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] expected_command;
        logic [LEN_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             frame_end;
        t_status          status;
        logic [LEN_W-1:0] payload_length;
    } t_result;

endpackage

@@ rtl/core/nfcfr_parser.sv @@
// Frame parser state and the per-beat decode of one received byte.
module nfcfr_parser
    import nfcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic [7:0] i_byte,
    input  t_cfg    i_cfg,
    output logic    o_emit,
    output t_result o_result
);

    t_phase           r_phase, n_phase;
    logic [2:0]       r_byte_index, n_byte_index;
    logic [39:0]      r_header_bytes, n_header_bytes;
    logic [7:0]       r_length_high, n_length_high;
    logic [LEN_W-1:0] r_frame_length, n_frame_length;
    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]       r_data_sum, n_data_sum;
    logic [7:0]       r_direction_byte, n_direction_byte;
    logic [7:0]       r_checksum_byte, n_checksum_byte;

    logic [39:0]      hdr_shift;
    logic [7:0]       hdr_len;
    logic [7:0]       resp_code;
    logic [7:0]       ext_sum;
    logic             chk_en;
    logic [LEN_W-1:0] chk_raw;
    logic [LEN_W-1:0] chk_len;
    logic             fin;
    t_status          fin_status;
    logic [LEN_W-1:0] fin_len;

    assign hdr_shift = {r_header_bytes[31:0], i_byte};
    assign hdr_len   = hdr_shift[15:8];
    assign resp_code = i_cfg.expected_command + 8'd1;
    assign ext_sum   = r_length_high + r_frame_length[7:0] + i_byte;
    assign chk_len   = chk_raw - MIN_RAW_LEN;

    always_comb begin
        n_phase          = r_phase;
        n_byte_index     = r_byte_index;
        n_header_bytes   = r_header_bytes;
        n_length_high    = r_length_high;
        n_frame_length   = r_frame_length;
        n_bytes_left     = r_bytes_left;
        n_data_sum       = r_data_sum;
        n_direction_byte = r_direction_byte;
        n_checksum_byte  = r_checksum_byte;
        chk_en           = 1'b0;
        chk_raw          = '0;
        fin              = 1'b0;
        fin_status       = ST_OK;
        fin_len          = '0;
        o_emit           = 1'b0;
        o_result         = '0;

        case (r_phase)
            PH_HEADER: begin
                n_header_bytes = hdr_shift;
                if (r_byte_index < 3'd4) begin
                    n_byte_index = r_byte_index + 3'd1;
                end else begin
                    n_byte_index = '0;
                    if (hdr_shift[39:16] != START_CODE) begin
                        fin        = 1'b1;
                        fin_status = ST_START;
                    end else if (hdr_len == ERR_LEN_BYTE && i_byte == ALL_ONES_BYTE) begin
                        n_phase = PH_ERRSKIP;
                    end else if (hdr_len == ALL_ONES_BYTE && i_byte == ALL_ONES_BYTE) begin
                        n_phase = PH_EXTLEN;
                    end else if (({1'b0, hdr_len} + {1'b0, i_byte}) != NORMAL_LEN_SUM) begin
                        fin        = 1'b1;
                        fin_status = ST_LEN_CSUM;
                    end else begin
                        chk_en  = 1'b1;
                        chk_raw = {8'h00, hdr_len};
                    end
                end
            end
            PH_ERRSKIP: begin
                if (r_byte_index < 3'd2) begin
                    n_byte_index = r_byte_index + 3'd1;
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_ERR_FRAME;
                end
            end
            PH_EXTLEN: begin
                case (r_byte_index)
                    3'd0: begin
                        n_length_high = i_byte;
                        n_byte_index  = 3'd1;
                    end
                    3'd1: begin
                        n_frame_length = {r_length_high, i_byte};
                        n_byte_index   = 3'd2;
                    end
                    default: begin
                        n_byte_index = '0;
                        if (ext_sum != 8'h00) begin
                            fin        = 1'b1;
                            fin_status = ST_LEN_CSUM;
                        end else begin
                            chk_en  = 1'b1;
                            chk_raw = r_frame_length;
                        end
                    end
                endcase
            end
            PH_DIR: begin
                n_direction_byte = i_byte;
                n_phase          = PH_CODE;
            end
            PH_CODE: begin
                if (r_direction_byte != DIR_BYTE) begin
                    fin        = 1'b1;
                    fin_status = ST_DIRECTION;
                end else if (i_byte != resp_code) begin
                    fin        = 1'b1;
                    fin_status = ST_RESP_CODE;
                end else begin
                    n_data_sum   = DCS_SEED - resp_code;
                    n_bytes_left = r_frame_length;
                    n_phase      = (r_frame_length != '0) ? PH_DATA : PH_DCS;
                end
            end
            PH_DATA: begin
                n_data_sum            = r_data_sum - i_byte;
                n_bytes_left          = r_bytes_left - 16'd1;
                if (r_bytes_left == 16'd1) begin
                    n_phase = PH_DCS;
                end
                o_emit                 = 1'b1;
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_byte;
            end
            PH_DCS: begin
                n_checksum_byte = i_byte;
                n_phase         = PH_POST;
            end
            PH_POST: begin
                fin = 1'b1;
                if (r_checksum_byte != r_data_sum) begin
                    fin_status = ST_DATA_CSUM;
                end else if (i_byte != POSTAMBLE) begin
                    fin_status = ST_POSTAMBLE;
                end else begin
                    fin_status = ST_OK;
                    fin_len    = r_frame_length;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        if (chk_en) begin
            if (chk_raw < MIN_RAW_LEN || chk_len > i_cfg.max_payload) begin
                fin        = 1'b1;
                fin_status = ST_TOO_LONG;
            end else begin
                n_frame_length = chk_len;
                n_phase        = PH_DIR;
            end
        end

        if (fin) begin
            n_phase                 = PH_HEADER;
            n_byte_index            = '0;
            o_emit                  = 1'b1;
            o_result.frame_end      = 1'b1;
            o_result.status         = fin_status;
            o_result.payload_length = fin_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_index <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_header_bytes   <= n_header_bytes;
            r_length_high    <= n_length_high;
            r_frame_length   <= n_frame_length;
            r_bytes_left     <= n_bytes_left;
            r_data_sum       <= n_data_sum;
            r_direction_byte <= n_direction_byte;
            r_checksum_byte  <= n_checksum_byte;
        end
    end

`ifndef SYNTH
    a_data_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_bytes_left != '0)
        else $error("Data phase entered with no bytes left.");

    a_header_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_byte_index < 3'd5)
        else $error("Header byte index out of range.");

    a_skip_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERRSKIP || r_phase == PH_EXTLEN) |-> r_byte_index < 3'd3)
        else $error("Skip or extended length index out of range.");

    a_finish_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && o_result.frame_end) |=> r_phase == PH_HEADER && r_byte_index == '0)
        else $error("Parser did not restart at the header after a frame end.");
`endif

endmodule

@@ rtl/core/nfc_controller_frame_receiver_unit.sv @@
// Top level of the NFC controller frame receiver: input stage, config and result register.
// A byte is held in the input register until decoded, and its result is then registered.
// Throughput: one byte per cycle unless the output stalls; the input and result registers each
// hold one beat; a byte is decoded when the result register is free or drains at that edge.
// Reset: synchronous, active low; the parser returns to the header phase, both stages empty,
// expected_command clears to zero and max_payload returns to 264.
module nfc_controller_frame_receiver_unit
    import nfcfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_payload_valid,
    output logic [7:0]           o_payload_byte,
    output logic                 o_frame_end,
    output logic [3:0]           o_status,
    output logic [LEN_W-1:0]     o_payload_length,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       step;
    logic       emit;
    t_result    result;

    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_command <= '0;
            r_cfg.max_payload      <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EXPECTED_COMMAND: r_cfg.expected_command <= i_cfg_data[CMD_W-1:0];
                CFG_MAX_PAYLOAD:      r_cfg.max_payload      <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nfcfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_frame_end      = r_out.frame_end;
    assign o_status         = r_out.status;
    assign o_payload_length = r_out.payload_length;

`ifndef SYNTH
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_payload_valid, o_frame_end}))
        else $error("A result beat must be either a payload byte or a frame end.");

    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_payload_length == '0)
        else $error("Payload length set on an error result.");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("Input stalled while the pipeline can move.");
`endif

endmodule
